[sv/sds_pkg.sv]
// ----------------------------------------------------------------------------
// SCAN disk scheduler package
// Shared widths, codes, structs and a helper function of the scheduler.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int unsigned MAX_REQUESTS = 32;
  localparam int unsigned CYL_W        = 12;
  localparam int unsigned AMT_W        = 13;
  localparam int unsigned IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = CYL_W;

  localparam logic [CYL_W-1:0] MAX_CYL_RESET = CYL_W'(199);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWEEP_RIGHT = 1'b0,
    CFG_MAX_CYL     = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_CYL   = 2'd0,
    KIND_TOTAL = 2'd1,
    KIND_ACK   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_CMP,
    ST_LD_PUT,
    ST_LD_ACK,
    ST_SCAN,
    ST_HEAD,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_TOTAL
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [AMT_W-1:0]   amount;
    logic               overflow;
    logic               last;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [CYL_W-1:0]   wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  function automatic logic [CYL_W-1:0] clamp_cyl(input logic [CYL_W-1:0] v,
                                                 input logic [CYL_W-1:0] max_cyl);
    clamp_cyl = (v > max_cyl) ? max_cyl : v;
  endfunction

endpackage

[sv/sds_in_if.sv]
// ----------------------------------------------------------------------------
// Scheduler input channel
// Valid/ready channel carrying one command and its cylinder.
// ----------------------------------------------------------------------------
interface sds_in_if;
  import sds_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [CYL_W-1:0] cylinder;

  modport source (output valid, output command, output cylinder, input ready);
  modport sink   (input valid, input command, input cylinder, output ready);
endinterface

[sv/sds_out_if.sv]
// ----------------------------------------------------------------------------
// Scheduler output channel
// Valid/ready channel carrying one scheduling result.
// ----------------------------------------------------------------------------
interface sds_out_if;
  import sds_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [AMT_W-1:0] amount;
  logic             overflow;
  logic             last;

  modport source (output valid, output kind, output amount, output overflow,
                  output last, input ready);
  modport sink   (input valid, input kind, input amount, input overflow,
                  input last, output ready);
endinterface

[sv/sds_ram.sv]
// ----------------------------------------------------------------------------
// Request store
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sds_ram (
  input  logic                     clk_i,
  input  sds_pkg::mem_req_t        req_i,
  output logic [sds_pkg::CYL_W-1:0] rdata_o
);
  import sds_pkg::*;

  logic [CYL_W-1:0] mem_q [MAX_REQUESTS];
  logic [CYL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[sv/sds_out_reg.sv]
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the sink takes it; reports when a new one fits.
// ----------------------------------------------------------------------------
module sds_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sds_pkg::result_t  res_i,
  output logic              free_o,
  sds_out_if.source         out_o
);
  import sds_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = push_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.kind     = res_q.kind;
  assign out_o.amount   = res_q.amount;
  assign out_o.overflow = res_q.overflow;
  assign out_o.last     = res_q.last;
endmodule

[sv/sds_ctrl.sv]
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequencer that inserts and acknowledges loads in the sorted store, scans it
// on a start and emits the service order and the total seek distance.
// ----------------------------------------------------------------------------
module sds_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sds_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  sds_in_if.sink                        in_i,
  input  logic                          out_free_i,
  output logic                          push_o,
  output sds_pkg::result_t              push_res_o,
  output sds_pkg::mem_req_t             mem_req_o,
  input  logic [sds_pkg::CYL_W-1:0]     mem_rdata_i
);
  import sds_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             sweep_right_q;
  logic [CYL_W-1:0] max_cyl_q;
  logic             rv_q, rv_d;

  logic [CYL_W-1:0] cyl_q, cyl_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] iss_q, iss_d;
  logic             rfirst_q, rfirst_d;
  logic             rlast_q, rlast_d;
  logic [CNT_W-1:0] below_q, below_d;
  logic [CYL_W-1:0] lo_q, lo_d;
  logic [CYL_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] up_q, up_d;
  logic [CNT_W-1:0] dn_q, dn_d;

  logic [CYL_W-1:0] in_clamped;
  logic [CYL_W-1:0] rd_clamped;
  logic             want_up;
  logic [AMT_W-1:0] tot_main;
  logic [AMT_W-1:0] tot_extra;

  assign in_clamped = clamp_cyl(in_i.cylinder, max_cyl_q);
  assign rd_clamped = clamp_cyl(mem_rdata_i, max_cyl_q);
  assign in_i.ready = (state_q == ST_IDLE);

  // After the first sweep runs out, the other side is taken until it is empty.
  assign want_up = sweep_right_q ? (up_q < count_q) : (dn_q == '0);

  always_comb begin
    if (sweep_right_q) begin
      tot_main  = AMT_W'(max_cyl_q) - AMT_W'(cyl_q);
      tot_extra = (below_q != '0) ? (AMT_W'(max_cyl_q) - AMT_W'(lo_q)) : '0;
    end else begin
      tot_main  = AMT_W'(cyl_q);
      tot_extra = (count_q > below_q) ? AMT_W'(hi_q) : '0;
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rv_d       = 1'b0;
    cyl_d      = cyl_q;
    pos_d      = pos_q;
    ovf_d      = ovf_q;
    iss_d      = iss_q;
    rfirst_d   = rfirst_q;
    rlast_d    = rlast_q;
    below_d    = below_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    up_d       = up_q;
    dn_d       = dn_q;
    push_o     = 1'b0;
    push_res_o = '{kind: KIND_CYL, amount: '0, overflow: 1'b0, last: 1'b0};
    mem_req_o  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cyl_d = in_clamped;
          if (in_i.command == CMD_START) begin
            below_d = '0;
            iss_d   = '0;
            state_d = (count_q == '0) ? ST_HEAD : ST_SCAN;
          end else if (count_q >= CNT_W'(MAX_REQUESTS)) begin
            ovf_d   = 1'b1;
            state_d = ST_LD_ACK;
          end else if (count_q == '0) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = '0;
            mem_req_o.wdata = in_clamped;
            count_d         = CNT_W'(1);
            ovf_d           = 1'b0;
            state_d         = ST_LD_ACK;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = IDX_W'(count_q - CNT_W'(1));
            pos_d           = count_q;
            ovf_d           = 1'b0;
            state_d         = ST_LD_CMP;
          end
        end
      end

      // Entry pos-1 is on the read port; shift it up or drop the new value in.
      ST_LD_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = IDX_W'(pos_q);
        if (mem_rdata_i > cyl_q) begin
          mem_req_o.wdata = mem_rdata_i;
          pos_d           = pos_q - CNT_W'(1);
          if (pos_q == CNT_W'(1)) begin
            state_d = ST_LD_PUT;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = IDX_W'(pos_q - CNT_W'(2));
          end
        end else begin
          mem_req_o.wdata = cyl_q;
          count_d         = count_q + CNT_W'(1);
          state_d         = ST_LD_ACK;
        end
      end

      ST_LD_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = '0;
        mem_req_o.wdata = cyl_q;
        count_d         = count_q + CNT_W'(1);
        state_d         = ST_LD_ACK;
      end

      ST_LD_ACK: begin
        if (out_free_i) begin
          push_o     = 1'b1;
          push_res_o = '{kind: KIND_ACK, amount: '0, overflow: ovf_q, last: 1'b1};
          state_d    = ST_IDLE;
        end
      end

      // Reads are issued back to back; each read's data comes back in the following cycle.
      ST_SCAN: begin
        if (iss_q < count_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = IDX_W'(iss_q);
          iss_d           = iss_q + CNT_W'(1);
          rv_d            = 1'b1;
          rfirst_d        = (iss_q == '0);
          rlast_d         = (iss_q == count_q - CNT_W'(1));
        end
        if (rv_q) begin
          if (rd_clamped < cyl_q) begin
            below_d = below_q + CNT_W'(1);
          end
          if (rfirst_q) begin
            lo_d = rd_clamped;
          end
          hi_d = rd_clamped;
          if (rlast_q) begin
            state_d = ST_HEAD;
          end
        end
      end

      ST_HEAD: begin
        up_d = below_q;
        dn_d = below_q;
        if (out_free_i) begin
          push_o     = 1'b1;
          push_res_o = '{kind: KIND_CYL, amount: AMT_W'(cyl_q), overflow: 1'b0,
                         last: 1'b0};
          state_d    = ST_EMIT_RD;
        end
      end

      ST_EMIT_RD: begin
        if (want_up && (up_q < count_q)) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = IDX_W'(up_q);
          up_d            = up_q + CNT_W'(1);
          state_d         = ST_EMIT_OUT;
        end else if (!want_up && (dn_q != '0)) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = IDX_W'(dn_q - CNT_W'(1));
          dn_d            = dn_q - CNT_W'(1);
          state_d         = ST_EMIT_OUT;
        end else begin
          state_d = ST_TOTAL;
        end
      end

      // The read data stays put until the next read, so a stall is harmless.
      ST_EMIT_OUT: begin
        if (out_free_i) begin
          push_o     = 1'b1;
          push_res_o = '{kind: KIND_CYL, amount: AMT_W'(rd_clamped), overflow: 1'b0,
                         last: 1'b0};
          state_d    = ST_EMIT_RD;
        end
      end

      ST_TOTAL: begin
        if (out_free_i) begin
          push_o     = 1'b1;
          push_res_o = '{kind: KIND_TOTAL, amount: tot_main + tot_extra,
                         overflow: 1'b0, last: 1'b1};
          count_d    = '0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      rv_q          <= 1'b0;
      sweep_right_q <= 1'b1;
      max_cyl_q     <= MAX_CYL_RESET;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SWEEP_RIGHT) begin
          sweep_right_q <= cfg_wdata_i[0];
        end else begin
          max_cyl_q <= cfg_wdata_i[CYL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cyl_q    <= cyl_d;
    pos_q    <= pos_d;
    ovf_q    <= ovf_d;
    iss_q    <= iss_d;
    rfirst_q <= rfirst_d;
    rlast_q  <= rlast_d;
    below_q  <= below_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    up_q     <= up_d;
    dn_q     <= dn_d;
  end
endmodule

[sv/scan_disk_scheduler.sv]
// ----------------------------------------------------------------------------
// SCAN disk scheduler
// Elevator scheduler: loads build a sorted request store, a start emits the
// service order from the head position and the total seek distance.
// ----------------------------------------------------------------------------
// A load transaction into a store that already holds requests reads the last
// stored entry and then moves every stored request larger than the new one up
// by one place, one entry per cycle through the request store, before the new
// one is written into the gap and acknowledged. A load into an empty store is
// written to the first entry; a load into a full store is dropped and
// acknowledged with overflow set. A start transaction is accepted and scans the
// store once (the scan is skipped when the store is empty). It emits the head
// and then each serviced request (one memory read, one result), finds the order
// exhausted and emits the total seek distance last. A result sink that holds
// back stalls the transaction. The store is empty afterwards. The store needs
// no clearing after reset. Configuration must be written only while no
// transaction is in progress, which the block leaves to the user to ensure.
module scan_disk_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sds_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  sds_in_if.sink                         in_i,
  sds_out_if.source                      out_o
);
  import sds_pkg::*;

  mem_req_t         mem_req;
  logic [CYL_W-1:0] mem_rdata;
  logic             out_free;
  logic             push;
  result_t          push_res;

  sds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_free_i  (out_free),
    .push_o      (push),
    .push_res_o  (push_res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  sds_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  sds_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res_i  (push_res),
    .free_o (out_free),
    .out_o  (out_o)
  );
endmodule

[sim/scan_disk_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// SCAN disk scheduler testbench
// Drives load and start transactions through the input channel, predicts the
// service order, seek totals and load acknowledgements, and checks every
// result. A directed table comes first, then random request sessions under
// changing sweep direction and disk size, with random gaps and stalls.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_tb;
  import sds_pkg::*;

  localparam int N_ITEMS       = 410;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int TIMEOUT       = 8_000_000;
  localparam int N_DIR         = 31;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e        rk;
    cmd_e             cmd;
    cfg_idx_e         idx;
    logic [CYL_W-1:0] value;
    logic             typed;
    result_t          res;
  } dir_row_t;

  localparam result_t NO_RES = '0;
  localparam result_t ACK_OK = '{KIND_ACK, 13'd0, 1'b0, 1'b1};

  logic                  clk_i;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sds_in_if  in_ch ();
  sds_out_if out_ch ();

  scan_disk_scheduler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.source)
  );

  // Predictor state: the sorted request list and the live configuration.
  logic [CYL_W-1:0] pending_cyl_q [$];
  logic             sweep_up_q;
  logic [CYL_W-1:0] max_cyl_q;
  result_t          service_q [$];
  logic [CYL_W-1:0] last_cyl;

  bit feed_gaps;
  bit steady_phase;
  int fail_cnt, n_items, n_starts, n_drops, n_results, n_cfg;

  // Directed table: loads, starts and register writes. Only the final result
  // of a row is typed in, and only where it is obvious.
  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd50,   1'b1, ACK_OK},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd4095, 1'b1, ACK_OK},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd0,    1'b1, ACK_OK},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd50,   1'b0, NO_RES},
    '{ROW_ITEM, CMD_START, CFG_SWEEP_RIGHT, 12'd50,   1'b1,
      '{KIND_TOTAL, 13'd348, 1'b0, 1'b1}},
    '{ROW_CFG,  CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd0,    1'b0, NO_RES},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd10,   1'b0, NO_RES},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd3000, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_START, CFG_SWEEP_RIGHT, 12'd4095, 1'b1,
      '{KIND_TOTAL, 13'd398, 1'b0, 1'b1}},
    '{ROW_CFG,  CMD_LOAD,  CFG_MAX_CYL,     12'd4095, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd4095, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd0,    1'b0, NO_RES},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd2048, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_START, CFG_SWEEP_RIGHT, 12'd0,    1'b1,
      '{KIND_TOTAL, 13'd4095, 1'b0, 1'b1}},
    '{ROW_CFG,  CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd1,    1'b0, NO_RES},
    '{ROW_ITEM, CMD_START, CFG_SWEEP_RIGHT, 12'd4095, 1'b1,
      '{KIND_TOTAL, 13'd0, 1'b0, 1'b1}},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd0,    1'b0, NO_RES},
    '{ROW_ITEM, CMD_START, CFG_SWEEP_RIGHT, 12'd1,    1'b1,
      '{KIND_TOTAL, 13'd8189, 1'b0, 1'b1}},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'hAAA,  1'b0, NO_RES},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'h555,  1'b0, NO_RES},
    '{ROW_CFG,  CMD_LOAD,  CFG_MAX_CYL,     12'd1000, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_START, CFG_SWEEP_RIGHT, 12'd500,  1'b1,
      '{KIND_TOTAL, 13'd500, 1'b0, 1'b1}},
    '{ROW_CFG,  CMD_LOAD,  CFG_MAX_CYL,     12'd0,    1'b0, NO_RES},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd123,  1'b0, NO_RES},
    '{ROW_ITEM, CMD_START, CFG_SWEEP_RIGHT, 12'd77,   1'b1,
      '{KIND_TOTAL, 13'd0, 1'b0, 1'b1}},
    '{ROW_CFG,  CMD_LOAD,  CFG_MAX_CYL,     12'd199,  1'b0, NO_RES},
    '{ROW_CFG,  CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd0,    1'b0, NO_RES},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd7,    1'b0, NO_RES},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd7,    1'b0, NO_RES},
    '{ROW_ITEM, CMD_LOAD,  CFG_SWEEP_RIGHT, 12'd3,    1'b0, NO_RES},
    '{ROW_ITEM, CMD_START, CFG_SWEEP_RIGHT, 12'd7,    1'b1,
      '{KIND_TOTAL, 13'd14, 1'b0, 1'b1}}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT);
    $display("timeout with %0d results outstanding", service_q.size());
    $display("scan_disk_scheduler verification failed");
    $finish;
  end

  task automatic flag_error(input string what);
    $display("ERROR @%0t: %s", $time, what);
    fail_cnt++;
  endtask

  function automatic void expect_result(input kind_e k, input logic [AMT_W-1:0] a,
                                        input logic ovf, input logic lst);
    result_t r;
    r = '{k, a, ovf, lst};
    service_q.push_back(r);
  endfunction

  // Works out every result of one accepted transaction and updates the
  // request list the way the scheduler does.
  function automatic void schedule_service(input cmd_e cmd, input logic [CYL_W-1:0] cyl);
    logic [CYL_W-1:0] c;
    logic [CYL_W-1:0] req [$];
    int               below, pos, i, total;
    c = (cyl > max_cyl_q) ? max_cyl_q : cyl;
    if (cmd == CMD_LOAD) begin
      if (pending_cyl_q.size() >= MAX_REQUESTS) begin
        n_drops++;
        expect_result(KIND_ACK, '0, 1'b1, 1'b1);
      end else begin
        // A new request goes behind stored requests of equal value.
        pos = pending_cyl_q.size();
        while (pos > 0 && pending_cyl_q[pos-1] > c) pos--;
        pending_cyl_q.insert(pos, c);
        expect_result(KIND_ACK, '0, 1'b0, 1'b1);
      end
    end else begin
      n_starts++;
      below = 0;
      // Stored entries are clamped again, since the disk may have shrunk.
      foreach (pending_cyl_q[j]) begin
        req.push_back((pending_cyl_q[j] > max_cyl_q) ? max_cyl_q : pending_cyl_q[j]);
        if (req[j] < c) below++;
      end
      expect_result(KIND_CYL, AMT_W'(c), 1'b0, 1'b0);
      if (sweep_up_q) begin
        for (i = below; i < req.size(); i++) expect_result(KIND_CYL, AMT_W'(req[i]), 1'b0, 1'b0);
        for (i = below - 1; i >= 0; i--) expect_result(KIND_CYL, AMT_W'(req[i]), 1'b0, 1'b0);
        total = int'(max_cyl_q) - int'(c);
        if (below > 0) total += int'(max_cyl_q) - int'(req[0]);
      end else begin
        for (i = below - 1; i >= 0; i--) expect_result(KIND_CYL, AMT_W'(req[i]), 1'b0, 1'b0);
        for (i = below; i < req.size(); i++) expect_result(KIND_CYL, AMT_W'(req[i]), 1'b0, 1'b0);
        total = int'(c);
        if (req.size() > below) total += int'(req[req.size()-1]);
      end
      expect_result(KIND_TOTAL, AMT_W'(total), 1'b0, 1'b1);
      pending_cyl_q.delete();
    end
  endfunction

  task automatic send_item(input cmd_e cmd, input logic [CYL_W-1:0] cyl,
                           input logic typed, input result_t typed_res);
    if (feed_gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.cylinder <= cyl;
    do @(posedge clk_i); while (!in_ch.ready);
    schedule_service(cmd, cyl);
    if (typed) service_q[service_q.size()-1] = typed_res;
    n_items++;
  endtask

  // Holds the sender back until every expected result is out and the
  // scheduler has had time to finish any trailing work.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (service_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_SWEEP_RIGHT) sweep_up_q = val[0];
    else max_cyl_q = val;
    n_cfg++;
  endtask

  function automatic logic [CYL_W-1:0] pick_max_cyl();
    case ($urandom_range(0, 5))
      0:       pick_max_cyl = CYL_W'(1);
      1:       pick_max_cyl = CYL_W'(4095);
      2:       pick_max_cyl = MAX_CYL_RESET;
      3:       pick_max_cyl = CYL_W'($urandom_range(2, 15));
      default: pick_max_cyl = CYL_W'($urandom_range(1, 4095));
    endcase
  endfunction

  // Mostly in range, with edges, out of range values and repeats mixed in.
  function automatic logic [CYL_W-1:0] pick_cyl();
    case ($urandom_range(0, 9))
      0:       pick_cyl = '0;
      1:       pick_cyl = max_cyl_q;
      2:       pick_cyl = CYL_W'($urandom_range(max_cyl_q, 4095));
      3:       pick_cyl = last_cyl;
      4, 5:    pick_cyl = CYL_W'($urandom_range(0, 4095));
      default: pick_cyl = CYL_W'($urandom_range(0, max_cyl_q));
    endcase
    last_cyl = pick_cyl;
  endfunction

  task automatic check_result();
    result_t want;
    if (service_q.size() == 0) begin
      flag_error($sformatf("unexpected result kind=%0d amount=%0d ovf=%0b last=%0b",
                           out_ch.kind, out_ch.amount, out_ch.overflow, out_ch.last));
    end else begin
      want = service_q.pop_front();
      n_results++;
      if (out_ch.kind !== want.kind || out_ch.amount !== want.amount ||
          out_ch.overflow !== want.overflow || out_ch.last !== want.last)
        flag_error($sformatf("result %0d: got %0d/%0d/%0b/%0b want %0d/%0d/%0b/%0b",
                             n_results, out_ch.kind, out_ch.amount, out_ch.overflow,
                             out_ch.last, want.kind, want.amount, want.overflow,
                             want.last));
    end
  endtask

  initial begin : result_sink
    int stall_left;
    bit busy_mode;
    stall_left   = 0;
    busy_mode    = 1'b1;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_n && out_ch.valid && out_ch.ready) check_result();
      if ($urandom_range(0, 199) == 0) busy_mode = !busy_mode;
      if (steady_phase) stall_left = 0;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!steady_phase && busy_mode && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int sess, n_loads, k, drain;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_LOAD;
    in_ch.cylinder = '0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_SWEEP_RIGHT;
    cfg_wdata      = '0;
    sweep_up_q     = 1'b1;
    max_cyl_q      = MAX_CYL_RESET;
    last_cyl       = '0;
    feed_gaps      = 1'b1;
    steady_phase   = 1'b0;
    rst_n          = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].rk == ROW_CFG) begin
        wait_idle();
        write_cfg(dir_rows[r].idx, dir_rows[r].value);
      end else begin
        send_item(dir_rows[r].cmd, dir_rows[r].value, dir_rows[r].typed, dir_rows[r].res);
      end
    end

    // Random sessions: a run of loads closed by a start. Every fifth session
    // overfills the store so that dropped loads show up regularly. The final
    // stretch keeps the configuration fixed so that nothing pauses the input.
    sess = 0;
    while (n_items < N_ITEMS) begin
      steady_phase = (n_items > N_ITEMS * 85 / 100);
      feed_gaps    = !steady_phase && $urandom_range(0, 3) != 0;
      if (!steady_phase && (sess == 0 || $urandom_range(0, 2) == 0)) begin
        wait_idle();
        if (sess == 0 || $urandom_range(0, 1) == 1)
          write_cfg(CFG_SWEEP_RIGHT, CFG_DATA_W'($urandom_range(0, 1)));
        if (sess == 0 || $urandom_range(0, 1) == 1)
          write_cfg(CFG_MAX_CYL, pick_max_cyl());
      end
      if (sess % 5 == 1) n_loads = MAX_REQUESTS + $urandom_range(1, 4);
      else if ($urandom_range(0, 5) == 0) n_loads = $urandom_range(11, MAX_REQUESTS);
      else n_loads = $urandom_range(0, 10);
      for (k = 0; k < n_loads; k++) begin
        // Occasionally resize the disk while requests are stored.
        if (!steady_phase && $urandom_range(0, 39) == 0) begin
          wait_idle();
          write_cfg(CFG_MAX_CYL, pick_max_cyl());
        end
        send_item(CMD_LOAD, pick_cyl(), 1'b0, NO_RES);
      end
      send_item(CMD_START, pick_cyl(), 1'b0, NO_RES);
      sess++;
    end

    in_ch.valid <= 1'b0;
    drain = 0;
    while (service_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (service_q.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", service_q.size()));

    $display("Covered %0d transactions in %0d sessions: %0d starts, %0d dropped loads.",
             n_items, sess, n_starts, n_drops);
    $display("Checked %0d results across %0d register writes, %0d mismatches.",
             n_results, n_cfg, fail_cnt);
    if (fail_cnt == 0)
      $display("scan_disk_scheduler verification clean");
    else
      $display("scan_disk_scheduler verification failed");
    $finish;
  end

endmodule

[files.f]
sv/sds_pkg.sv
sv/sds_in_if.sv
sv/sds_out_if.sv
sv/sds_ram.sv
sv/sds_out_reg.sv
sv/sds_ctrl.sv
sv/scan_disk_scheduler.sv
sim/scan_disk_scheduler_tb.sv
